@@ rtl/tshb_pkg.sv @@
// Shared types, sizes and helpers for the time-sorted hit buffer.
`timescale 1ns / 1ps

package tshb_pkg;

   localparam int DEPTH     = 1024;
   localparam int TIME_BITS = 32;

   // Fixed field widths of the transaction payloads
   localparam int CMD_W    = 2;
   localparam int HTIME_W  = 32;
   localparam int CREATE_W = 8;
   localparam int SENSOR_W = 10;
   localparam int RIDX_W   = 10;
   localparam int OCNT_W   = 11;

   // Record count and selection tree sizing
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int GRP      = 32;
   localparam int GRP_W    = $clog2(GRP);
   localparam int GCNT_W   = GRP_W + 1;
   localparam int NGRP     = (DEPTH + GRP - 1) / GRP;
   localparam int GRPIDX_W = (NGRP > 1) ? $clog2(NGRP) : 1;
   localparam int NGRP_PAD = 2 ** GRPIDX_W;
   localparam int SEL_W    = GRPIDX_W + GRP_W;
   localparam int NSLOT    = NGRP_PAD * GRP;
   localparam int POS_W    = SEL_W + 1;
   localparam int CMPW     = (RIDX_W > CNT_W) ? RIDX_W : CNT_W;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [HTIME_W-1:0]  hit_time;
      logic [CREATE_W-1:0] creator_code;
      logic [SENSOR_W-1:0] sensor_number;
      logic [RIDX_W-1:0]   read_index;
   } req_type;

   typedef struct packed {
      logic [OCNT_W-1:0]   insert_position;
      logic [OCNT_W-1:0]   entry_count;
      logic                dropped;
      logic                evicted;
      logic                read_valid;
      logic [HTIME_W-1:0]  read_time;
      logic [CREATE_W-1:0] read_creator;
      logic [SENSOR_W-1:0] read_sensor;
   } rsp_type;

   typedef struct packed {
      logic [TIME_BITS-1:0] hit_time;
      logic [CREATE_W-1:0]  creator_code;
      logic [SENSOR_W-1:0]  sensor_number;
   } rec_type;

   typedef struct packed {
      logic cmp_en;
      logic shift_en;
   } cell_ctl_type;

   function automatic logic [TIME_BITS-1:0] time_from_hit(input logic [HTIME_W-1:0] t);
      logic [63:0] wide;
      wide = 64'(t);
      return wide[TIME_BITS-1:0];
   endfunction

   function automatic logic [HTIME_W-1:0] time_to_read(input logic [TIME_BITS-1:0] t);
      logic [63:0] wide;
      wide = 64'(t);
      return wide[HTIME_W-1:0];
   endfunction

endpackage

@@ rtl/tshb_cell.sv @@
// One storage cell of the sorted chain: compare against the new time, then hold or shift.
`timescale 1ns / 1ps

module tshb_cell (
   input  logic                  clock,
   input  tshb_pkg::cell_ctl_type ctl,
   input  tshb_pkg::rec_type     new_rec,
   input  logic                  occupied,
   input  tshb_pkg::rec_type     left_rec,
   input  logic                  left_beyond,
   output tshb_pkg::rec_type     rec,
   output logic                  le
);
   import tshb_pkg::*;

   rec_type rec_ff, rec_in;
   logic    le_ff, le_in;

   // le: this cell holds a record that stays ahead of the new one
   always_comb begin
      le_in = ctl.cmp_en ? (occupied && (rec_ff.hit_time <= new_rec.hit_time)) : le_ff;
      rec_in = rec_ff;
      if (ctl.shift_en && !le_ff) begin
         rec_in = left_beyond ? left_rec : new_rec;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      le_ff  <= le_in;
   end

   assign rec = rec_ff;
   assign le  = le_ff;

endmodule

@@ rtl/tshb_chain.sv @@
// Row of DEPTH sorting cells, each but the head fed by its left neighbor.
`timescale 1ns / 1ps

module tshb_chain (
   input  logic                         clock,
   input  tshb_pkg::cell_ctl_type       ctl,
   input  tshb_pkg::rec_type            new_rec,
   input  logic [tshb_pkg::CNT_W-1:0]   count,
   output tshb_pkg::rec_type            recs [tshb_pkg::DEPTH],
   output logic [tshb_pkg::DEPTH-1:0]   le
);
   import tshb_pkg::*;

   logic [DEPTH-1:0] occupied;

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         assign occupied[i] = (CNT_W'(i) < count);
         if (i == 0) begin : g_head
            tshb_cell u_cell (
               .clock       (clock),
               .ctl         (ctl),
               .new_rec     (new_rec),
               .occupied    (occupied[i]),
               .left_rec    (new_rec),
               .left_beyond (1'b0),
               .rec         (recs[i]),
               .le          (le[i])
            );
         end else begin : g_body
            tshb_cell u_cell (
               .clock       (clock),
               .ctl         (ctl),
               .new_rec     (new_rec),
               .occupied    (occupied[i]),
               .left_rec    (recs[i-1]),
               .left_beyond (!le[i-1]),
               .rec         (recs[i]),
               .le          (le[i])
            );
         end
      end
   endgenerate

endmodule

@@ rtl/tshb_sel.sv @@
// Two-level registered selection tree: record at an index and insert position.
`timescale 1ns / 1ps

module tshb_sel (
   input  logic                         clock,
   input  tshb_pkg::rec_type            recs [tshb_pkg::DEPTH],
   input  logic [tshb_pkg::DEPTH-1:0]   le,
   input  logic [tshb_pkg::SEL_W-1:0]   sel_idx,
   output logic [tshb_pkg::POS_W-1:0]   pos,
   output tshb_pkg::rec_type            rec
);
   import tshb_pkg::*;

   rec_type              rec_grp [NGRP_PAD][GRP];
   logic [GRP-1:0]       le_grp [NGRP_PAD];
   rec_type              grp_rec_ff [NGRP_PAD];
   rec_type              grp_rec_in [NGRP_PAD];
   logic [GCNT_W-1:0]    grp_cnt_ff [NGRP_PAD];
   logic [GCNT_W-1:0]    grp_cnt_in [NGRP_PAD];
   logic [GRP_W-1:0]     idx_lo;
   logic [GRPIDX_W-1:0]  idx_hi;
   logic                 found;
   logic [GRPIDX_W-1:0]  first;

   assign idx_lo = sel_idx[GRP_W-1:0];
   assign idx_hi = sel_idx[SEL_W-1:GRP_W];

   genvar g, j;
   generate
      for (g = 0; g < NGRP_PAD; g++) begin : g_grp
         for (j = 0; j < GRP; j++) begin : g_slot
            if (g * GRP + j < DEPTH) begin : g_real
               assign rec_grp[g][j] = recs[g*GRP+j];
               assign le_grp[g][j]  = le[g*GRP+j];
            end else begin : g_pad
               assign rec_grp[g][j] = '0;
               assign le_grp[g][j]  = 1'b0;
            end
         end
      end
   endgenerate

   // The le flags form a run of ones from slot 0; binary search its length
   function automatic logic [GCNT_W-1:0] therm_count(input logic [GRP-1:0] bits);
      logic [GCNT_W-1:0] acc;
      logic [GCNT_W-1:0] trial;
      acc = '0;
      for (int b = GRP_W; b >= 0; b--) begin
         trial = acc | (GCNT_W'(1) << b);
         if (trial <= GCNT_W'(GRP) && bits[GRP_W'(trial - GCNT_W'(1))]) begin
            acc = trial;
         end
      end
      return acc;
   endfunction

   always_comb begin
      for (int k = 0; k < NGRP_PAD; k++) begin
         grp_rec_in[k] = rec_grp[k][idx_lo];
         grp_cnt_in[k] = therm_count(le_grp[k]);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NGRP_PAD; k++) begin
         grp_rec_ff[k] <= grp_rec_in[k];
         grp_cnt_ff[k] <= grp_cnt_in[k];
      end
   end

   // Second level: first group that is not full ends the run
   always_comb begin
      found = 1'b0;
      first = '0;
      for (int k = NGRP_PAD - 1; k >= 0; k--) begin
         if (grp_cnt_ff[k] != GCNT_W'(GRP)) begin
            found = 1'b1;
            first = GRPIDX_W'(k);
         end
      end
      if (found) begin
         pos = POS_W'({first, GRP_W'(0)}) + POS_W'(grp_cnt_ff[first]);
      end else begin
         pos = POS_W'(NSLOT);
      end
   end

   assign rec = grp_rec_ff[idx_hi];

endmodule

@@ rtl/time_sorted_hit_buffer.sv @@
// Top level of the time-sorted hit buffer: control sequencer, cell chain, readout tree.
`timescale 1ns / 1ps
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------
//   req     | in        | req_valid / req_ready   | req_payload (tshb_pkg::req_type)
//   rsp     | out       | rsp_valid / rsp_ready   | rsp_payload (tshb_pkg::rsp_type)
//
// Sequencing: one transaction at a time. Insert steps through a compare in
// all cells, a shift of the chain and the position resolved through the
// second tree level; read steps through the two tree levels; clear and the
// unused command go straight to the output stage.
// Reset clears the sequencer, the record count and the output valid flag;
// cell contents stay undefined until written and are never read before that.
// A full output register holds the sequencer in its last state; req_ready
// is high whenever the sequencer is idle, even while a result waits.

module time_sorted_hit_buffer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tshb_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tshb_pkg::rsp_type rsp_payload
);
   import tshb_pkg::*;

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
   localparam logic [ST_W-1:0] ST_CMP  = 3'd1;
   localparam logic [ST_W-1:0] ST_INS  = 3'd2;
   localparam logic [ST_W-1:0] ST_POS  = 3'd3;
   localparam logic [ST_W-1:0] ST_RD1  = 3'd4;
   localparam logic [ST_W-1:0] ST_RD2  = 3'd5;
   localparam logic [ST_W-1:0] ST_EMIT = 3'd6;

   logic [ST_W-1:0]  state_ff, state_in;
   req_type          req_ff, req_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             drop_ff, drop_in;
   logic             evict_ff, evict_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   cell_ctl_type     ctl;
   rec_type          new_rec;
   rec_type          recs [DEPTH];
   logic [DEPTH-1:0] le;
   logic [POS_W-1:0] pos;
   rec_type          sel_rec;
   logic             req_fire;
   logic             rsp_free;
   logic             full;
   logic             rd_ok;
   rsp_type          rsp_load;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign rd_ok     = (CMPW'(req_ff.read_index) < CMPW'(count_ff));

   assign new_rec.hit_time      = time_from_hit(req_ff.hit_time);
   assign new_rec.creator_code  = req_ff.creator_code;
   assign new_rec.sensor_number = req_ff.sensor_number;

   assign ctl.cmp_en   = (state_ff == ST_CMP);
   assign ctl.shift_en = (state_ff == ST_INS);

   tshb_chain u_chain (
      .clock   (clock),
      .ctl     (ctl),
      .new_rec (new_rec),
      .count   (count_ff),
      .recs    (recs),
      .le      (le)
   );

   tshb_sel u_sel (
      .clock   (clock),
      .recs    (recs),
      .le      (le),
      .sel_idx (SEL_W'(req_ff.read_index)),
      .pos     (pos),
      .rec     (sel_rec)
   );

   // Result word for whichever command finishes this cycle
   always_comb begin
      rsp_load = '0;
      rsp_load.entry_count = OCNT_W'(count_ff);
      case (state_ff)
         ST_POS: begin
            rsp_load.insert_position = OCNT_W'(pos);
            rsp_load.dropped         = drop_ff;
            rsp_load.evicted         = evict_ff;
         end
         ST_RD2: begin
            if (rd_ok) begin
               rsp_load.read_valid   = 1'b1;
               rsp_load.read_time    = time_to_read(sel_rec.hit_time);
               rsp_load.read_creator = sel_rec.creator_code;
               rsp_load.read_sensor  = sel_rec.sensor_number;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      evict_in     = evict_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               req_in = req_payload;
               case (req_payload.command)
                  CMD_INSERT: state_in = ST_CMP;
                  CMD_READ:   state_in = ST_RD1;
                  CMD_CLEAR: begin
                     count_in = '0;
                     state_in = ST_EMIT;
                  end
                  default:    state_in = ST_EMIT;
               endcase
            end
         end
         ST_CMP: begin
            state_in = ST_INS;
         end
         ST_INS: begin
            // Drop a late record on a full buffer; otherwise the last one falls off
            drop_in  = full && le[DEPTH-1];
            evict_in = full && !le[DEPTH-1];
            if (!full) begin
               count_in = count_ff + CNT_W'(1);
            end
            state_in = ST_POS;
         end
         ST_RD1: begin
            state_in = ST_RD2;
         end
         ST_POS, ST_RD2, ST_EMIT: begin
            if (rsp_free) begin
               rsp_in       = rsp_load;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff   <= req_in;
      drop_ff  <= drop_in;
      evict_ff <= evict_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("record count above depth");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_payload.command == CMD_CLEAR) |=> (count_ff == '0))
      else $error("clear did not empty the buffer");

   a_drop_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.dropped && rsp_ff.evicted))
      else $error("insert both dropped and evicted");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && count_ff >= CNT_W'(2))
         |-> (recs[0].hit_time <= recs[1].hit_time))
      else $error("first two records out of time order");
`endif

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the time-sorted hit buffer.
`timescale 1ns / 1ps

module testbench;

   import tshb_pkg::*;

   localparam int CLOCK_PERIOD = 10;
   localparam int RESET_CYCLES = 3;
   // Give up once this many cycles pass with no transaction on either channel
   localparam int STALL_LIMIT  = 3000;
   // Cycles to wait for stray responses once every expected one has arrived
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_ITEMS = 226;

   // The package names no code for the spare command value
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // Mirror of the buffer contents and the queue of responses still owed
   class hit_buffer_scoreboard;
      rec_type     records[DEPTH];
      int unsigned record_count = 0;
      rsp_type     pending[$];
      int unsigned error_count = 0;
      int unsigned insert_total = 0, drop_total = 0, evict_total = 0;
      int unsigned read_total = 0, read_miss_total = 0, clear_total = 0;
      int unsigned peak_count = 0;

      // Update the mirror for an accepted request and queue its response
      function void note_request(input req_type r);
         rsp_type              e;
         logic [TIME_BITS-1:0] t;
         int                   pos;
         int                   last;
         e = '0;
         t = r.hit_time;
         case (r.command)
            CMD_INSERT: begin
               insert_total++;
               // Land after every stored record with an equal or earlier time
               pos = 0;
               while (pos < int'(record_count) && records[pos].hit_time <= t)
                  pos++;
               if (record_count == DEPTH && pos == DEPTH) begin
                  e.dropped         = 1'b1;
                  e.insert_position = OCNT_W'(DEPTH);
                  drop_total++;
               end else begin
                  last = int'(record_count);
                  if (record_count == DEPTH) begin
                     e.evicted = 1'b1;
                     last      = DEPTH - 1;
                     evict_total++;
                  end
                  for (int i = last; i > pos; i--)
                     records[i] = records[i - 1];
                  records[pos].hit_time      = t;
                  records[pos].creator_code  = r.creator_code;
                  records[pos].sensor_number = r.sensor_number;
                  if (record_count < DEPTH)
                     record_count++;
                  e.insert_position = OCNT_W'(pos);
               end
            end
            CMD_READ: begin
               read_total++;
               if (r.read_index < record_count) begin
                  e.read_valid   = 1'b1;
                  e.read_time    = records[r.read_index].hit_time;
                  e.read_creator = records[r.read_index].creator_code;
                  e.read_sensor  = records[r.read_index].sensor_number;
               end else begin
                  read_miss_total++;
               end
            end
            CMD_CLEAR: begin
               clear_total++;
               record_count = 0;
            end
            default: ;
         endcase
         e.entry_count = OCNT_W'(record_count);
         if (record_count > peak_count)
            peak_count = record_count;
         pending = {pending, e};
      endfunction

      function void compare_field(input string name, input logic [63:0] expected,
                                  input logic [63:0] actual);
         if (actual !== expected) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, expected, actual);
            error_count++;
         end
      endfunction

      // Match an accepted response against the oldest outstanding request
      function void check_response(input rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("response arrived with no request outstanding");
            error_count++;
            return;
         end
         e = pending.pop_front();
         compare_field("insert_position", e.insert_position, a.insert_position);
         compare_field("entry_count",     e.entry_count,     a.entry_count);
         compare_field("dropped",         e.dropped,         a.dropped);
         compare_field("evicted",         e.evicted,         a.evicted);
         compare_field("read_valid",      e.read_valid,      a.read_valid);
         compare_field("read_time",       e.read_time,       a.read_time);
         compare_field("read_creator",    e.read_creator,    a.read_creator);
         compare_field("read_sensor",     e.read_sensor,     a.read_sensor);
      endfunction
   endclass

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   hit_buffer_scoreboard sb = new;

   // Percent of cycles in which each side holds off
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned request_total = 0;

   time_sorted_hit_buffer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic req_type make_request(input logic [CMD_W-1:0]    cmd,
                                            input logic [HTIME_W-1:0]  t,
                                            input logic [CREATE_W-1:0] cr,
                                            input logic [SENSOR_W-1:0] sn,
                                            input logic [RIDX_W-1:0]   idx);
      req_type r;
      r.command       = cmd;
      r.hit_time      = t;
      r.creator_code  = cr;
      r.sensor_number = sn;
      r.read_index    = idx;
      return r;
   endfunction

   // Mix the time extremes, a narrow range that makes equal times common,
   // and the full 32-bit range
   function automatic logic [HTIME_W-1:0] random_hit_time();
      case ($urandom_range(9))
         0:             return '0;
         1:             return '1;
         2, 3, 4, 5:    return HTIME_W'($urandom_range(15));
         default:       return HTIME_W'($urandom);
      endcase
   endfunction

   // Present one transaction, optionally after random idle cycles, and hold
   // it until the block takes it. Called right after a rising edge.
   task automatic send_request(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do
         @(posedge clock);
      while (!req_ready);
      sb.note_request(item);
      request_total++;
   endtask

   task automatic send_random_insert();
      send_request(make_request(CMD_INSERT, random_hit_time(), 8'($urandom),
                                10'($urandom), 10'($urandom)));
   endtask

   // Empty buffer, ordering of equal times, field extremes, reads on and
   // past the boundary, the spare command and clear
   task automatic run_directed();
      send_request(make_request(CMD_READ,   '0, '0, '0, '0));
      send_request(make_request(CMD_UNUSED, '1, '1, '1, '1));
      send_request(make_request(CMD_CLEAR,  '0, '0, '0, '0));
      send_request(make_request(CMD_INSERT, '1, 8'd255, 10'd1023, '0));
      send_request(make_request(CMD_INSERT, '0, 8'd0,   10'd0,    '1));
      send_request(make_request(CMD_INSERT, 32'd100, 8'd1, 10'd1, '0));
      send_request(make_request(CMD_INSERT, 32'd100, 8'd2, 10'd2, '0));
      send_request(make_request(CMD_INSERT, 32'd100, 8'd3, 10'd3, '0));
      send_request(make_request(CMD_INSERT, '0, 8'd4, 10'd4, '0));
      send_request(make_request(CMD_INSERT, '1, 8'd5, 10'd5, '0));
      // Walk every stored record, then step one past the end
      for (int i = 0; i <= 7; i++)
         send_request(make_request(CMD_READ, '0, '0, '0, 10'(i)));
      send_request(make_request(CMD_READ,   '1, '1, '1, '1));
      send_request(make_request(CMD_UNUSED, 32'h5A5A_A5A5, 8'hA5, 10'h2AA, 10'h155));
      send_request(make_request(CMD_CLEAR,  '1, '1, '1, '1));
      send_request(make_request(CMD_READ,   '0, '0, '0, '0));
   endtask

   // Short fill-and-read sequences between clears, with noise mixed in
   task automatic run_random(input int unsigned count);
      int unsigned  roll;
      logic [RIDX_W-1:0] idx;
      for (int unsigned k = 0; k < count; k++) begin
         roll = $urandom_range(99);
         if (roll < 52) begin
            send_random_insert();
         end else if (roll < 88) begin
            // Mostly stored positions, sometimes exactly the count, else anywhere
            case ($urandom_range(9))
               7:       idx = RIDX_W'(sb.record_count);
               8, 9:    idx = 10'($urandom);
               default: idx = (sb.record_count > 0) ?
                              RIDX_W'($urandom_range(sb.record_count - 1)) : '0;
            endcase
            send_request(make_request(CMD_READ, 32'($urandom), 8'($urandom),
                                      10'($urandom), idx));
         end else if (roll < 94) begin
            send_request(make_request(CMD_CLEAR, 32'($urandom), 8'($urandom),
                                      10'($urandom), 10'($urandom)));
         end else begin
            send_request(make_request(CMD_UNUSED, 32'($urandom), 8'($urandom),
                                      10'($urandom), 10'($urandom)));
         end
      end
   endtask

   // Check every accepted response and randomize the back-pressure
   initial begin : response_sink
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_response(rsp_payload);
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Abort when neither channel has moved a transaction for too long
   initial begin : watchdog
      int unsigned stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Slow receiver: responses back up while the sender keeps pushing
      send_idle_pct = 15;
      recv_idle_pct = 83;
      run_directed();
      run_random(RANDOM_ITEMS);

      // Slow sender: the block mostly waits for requests
      send_idle_pct = 83;
      recv_idle_pct = 15;
      run_random(RANDOM_ITEMS);

      // Full rate on both sides
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(RANDOM_ITEMS);
      req_valid <= 1'b0;

      // Drain the outstanding responses, then watch for stray ones
      while (sb.pending.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests: %0d inserts (%0d dropped, %0d evicting), %0d reads",
               request_total, sb.insert_total, sb.drop_total, sb.evict_total,
               sb.read_total);
      $display("  %0d reads past the stored count, %0d clears, peak occupancy %0d of %0d",
               sb.read_miss_total, sb.clear_total, sb.peak_count, DEPTH);
      if (sb.error_count == 0 && sb.pending.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

@@ time_sorted_hit_buffer.f @@
rtl/tshb_pkg.sv
rtl/tshb_cell.sv
rtl/tshb_chain.sv
rtl/tshb_sel.sv
rtl/time_sorted_hit_buffer.sv
bench/testbench.sv
